>>> hw/rtl/mtl_pkg.sv
// Shared types, character codes and token kind codes for the markup tag lexer.
package mtl_pkg;

    localparam int MAX_TAIL_NESTING  = 16;
    localparam int MAX_COMMENT_DEPTH = 255;
    localparam int QUEUE_DEPTH       = 4;

    localparam int TAIL_W  = $clog2(MAX_TAIL_NESTING + 1);
    localparam int DEPTH_W = $clog2(MAX_COMMENT_DEPTH + 1);
    localparam int QPTR_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W  = $clog2(QUEUE_DEPTH + 1);

    localparam logic [7:0] CH_BACKTICK = 8'h60;
    localparam logic [7:0] CH_SLASH    = 8'h2F;
    localparam logic [7:0] CH_STAR     = 8'h2A;
    localparam logic [7:0] CH_LF       = 8'h0A;
    localparam logic [7:0] CH_UNDER    = 8'h5F;
    localparam logic [7:0] CH_EQ       = 8'h3D;
    localparam logic [7:0] CH_SEMI     = 8'h3B;
    localparam logic [7:0] CH_COMMA    = 8'h2C;
    localparam logic [7:0] CH_LBRACE   = 8'h7B;
    localparam logic [7:0] CH_RBRACE   = 8'h7D;
    localparam logic [7:0] CH_DQUOTE   = 8'h22;
    localparam logic [7:0] CH_SQUOTE   = 8'h27;
    localparam logic [7:0] CH_NUL      = 8'h00;

    localparam logic [3:0] K_CONTENT  = 4'd0;
    localparam logic [3:0] K_DELIM    = 4'd1;
    localparam logic [3:0] K_BACKTICK = 4'd2;
    localparam logic [3:0] K_IDENT    = 4'd3;
    localparam logic [3:0] K_SPACE    = 4'd4;
    localparam logic [3:0] K_LCOMMENT = 4'd5;
    localparam logic [3:0] K_BCOMMENT = 4'd6;
    localparam logic [3:0] K_DQUOTE   = 4'd7;
    localparam logic [3:0] K_SQUOTE   = 4'd8;
    localparam logic [3:0] K_EQ       = 4'd9;
    localparam logic [3:0] K_SEMI     = 4'd10;
    localparam logic [3:0] K_COMMA    = 4'd11;
    localparam logic [3:0] K_LBRACE   = 4'd12;
    localparam logic [3:0] K_RBRACE   = 4'd13;
    localparam logic [3:0] K_UNKNOWN  = 4'd14;
    localparam logic [3:0] K_EOF      = 4'd15;

    typedef logic [TAIL_W-1:0]  t_tail;
    typedef logic [DEPTH_W-1:0] t_depth;

    typedef enum logic [2:0] {
        MODE_BODY = 3'b001,
        MODE_HEAD = 3'b010,
        MODE_TAIL = 3'b100
    } t_mode;

    typedef enum logic [2:0] {
        CK_NONE  = 3'b001,
        CK_LINE  = 3'b010,
        CK_BLOCK = 3'b100
    } t_ckind;

    // One accepted transaction, expanded into up to three results by the back end.
    typedef struct packed {
        logic [7:0] byte_a;
        logic [7:0] byte_b;
        logic       do_first;
        logic       do_second;
        logic       do_eof;
    } t_job;

    typedef struct packed {
        logic [7:0]  out_byte;
        logic [3:0]  kind;
        logic        start;
        logic [23:0] line_no;
        logic [15:0] col_no;
        logic        err;
        logic        last;
    } t_result;

endpackage

>>> hw/rtl/mtl_front.sv
// Front end: accepts transactions, keeps the one-byte hold and builds jobs.
module mtl_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  logic [7:0]    i_byte,
    input  logic          i_byte_valid,
    input  logic          i_end,
    input  logic          i_full,
    output logic          o_ready,
    output logic          o_push,
    output mtl_pkg::t_job o_job
);
    import mtl_pkg::*;

    logic [7:0] r_held_byte;
    logic       r_held_valid;
    logic       accept;

    assign o_ready = !i_full;
    assign accept  = i_valid && o_ready;

    always_comb begin
        o_job.byte_a    = r_held_byte;
        o_job.byte_b    = i_byte_valid ? i_byte : r_held_byte;
        o_job.do_first  = r_held_valid && i_byte_valid;
        o_job.do_second = i_end && (i_byte_valid || r_held_valid);
        o_job.do_eof    = i_end;
        o_push = accept && (o_job.do_first || o_job.do_second || o_job.do_eof);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held_byte  <= '0;
            r_held_valid <= 1'b0;
        end else if (accept) begin
            if (i_end) begin
                r_held_byte  <= '0;
                r_held_valid <= 1'b0;
            end else if (i_byte_valid) begin
                r_held_byte  <= i_byte;
                r_held_valid <= 1'b1;
            end
        end
    end

endmodule

>>> hw/rtl/mtl_queue.sv
// Short job queue between the front end and the back end.
module mtl_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  mtl_pkg::t_job i_job,
    input  logic          i_pop,
    output logic          o_full,
    output logic          o_empty,
    output mtl_pkg::t_job o_head
);
    import mtl_pkg::*;

    t_job              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QCNT_W-1:0] r_count;
    logic              do_push;
    logic              do_pop;

    assign o_full  = (r_count == QCNT_W'(QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_head  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

>>> hw/rtl/mtl_back.sv
// Back end: labels bytes in order, tracks lexer modes and drives the output register.
module mtl_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_empty,
    input  mtl_pkg::t_job    i_head,
    output logic             o_pop,
    output logic             o_valid,
    input  logic             i_ready,
    output mtl_pkg::t_result o_result
);
    import mtl_pkg::*;

    t_mode       r_mode,    n_mode;
    t_ckind      r_ckind,   n_ckind;
    t_tail       r_tail,    n_tail;
    t_depth      r_depth,   n_depth;
    logic [3:0]  r_run,     n_run;
    logic        r_pair,    n_pair;
    logic [23:0] r_line,    n_line;
    logic [15:0] r_col,     n_col;
    logic [2:0]  r_done;
    logic        r_out_valid;
    t_result     r_out;

    logic [2:0]  pend;
    logic [2:0]  sel;
    logic        fire;
    logic        is_last;
    logic [7:0]  c;
    logic [7:0]  la;
    logic        la_valid;
    logic [3:0]  kind;
    logic        st;
    logic        err;
    logic        alpha;
    logic        digit;
    logic        space;
    t_depth      dec_depth;

    assign pend    = {i_head.do_eof, i_head.do_second, i_head.do_first} & ~r_done;
    assign sel     = pend[0] ? 3'b001 : (pend[1] ? 3'b010 : (pend[2] ? 3'b100 : 3'b000));
    assign is_last = ((pend & ~sel) == 3'b000);
    assign fire    = !i_empty && (!r_out_valid || i_ready);
    assign o_pop   = fire && is_last;
    assign o_valid  = r_out_valid;
    assign o_result = r_out;

    assign c        = sel[0] ? i_head.byte_a : (sel[1] ? i_head.byte_b : 8'h00);
    assign la       = i_head.byte_b;
    assign la_valid = sel[0];
    assign alpha    = (c inside {[8'h61:8'h7A], [8'h41:8'h5A]});
    assign digit    = (c inside {[8'h30:8'h39]});
    assign space    = (c inside {8'h20, [8'h09:8'h0D]});
    assign dec_depth = (r_depth != '0) ? r_depth - 1'b1 : r_depth;

    always_comb begin
        n_mode  = r_mode;
        n_ckind = r_ckind;
        n_tail  = r_tail;
        n_depth = r_depth;
        n_pair  = r_pair;
        n_line  = r_line;
        n_col   = r_col;
        kind    = K_CONTENT;
        st      = 1'b1;
        err     = 1'b0;
        if (r_pair) begin
            n_pair = 1'b0;
            st     = 1'b0;
            kind   = r_run;
        end else if (r_ckind == CK_LINE) begin
            st   = 1'b0;
            kind = K_LCOMMENT;
            if (c == CH_LF) begin
                n_ckind = CK_NONE;
            end
        end else if (r_ckind == CK_BLOCK) begin
            st   = 1'b0;
            kind = K_BCOMMENT;
            if (c == CH_SLASH && la_valid && la == CH_STAR) begin
                if (r_depth < t_depth'(MAX_COMMENT_DEPTH)) begin
                    n_depth = r_depth + 1'b1;
                end else begin
                    err = 1'b1;
                end
                n_pair = 1'b1;
            end else if (c == CH_STAR && la_valid && la == CH_SLASH) begin
                n_depth = dec_depth;
                if (dec_depth == '0) begin
                    n_ckind = CK_NONE;
                end
                n_pair = 1'b1;
            end
        end else if (c == CH_SLASH && la_valid && la == CH_SLASH) begin
            n_ckind = CK_LINE;
            n_pair  = 1'b1;
            kind    = K_LCOMMENT;
        end else if (c == CH_SLASH && la_valid && la == CH_STAR) begin
            n_ckind = CK_BLOCK;
            n_depth = t_depth'(1);
            n_pair  = 1'b1;
            kind    = K_BCOMMENT;
        end else if (r_mode == MODE_HEAD) begin
            if (space) begin
                kind = K_SPACE;
                st   = (r_run != K_SPACE);
            end else if (r_run == K_IDENT && (alpha || digit || c == CH_UNDER)) begin
                kind = K_IDENT;
                st   = 1'b0;
            end else if (alpha || c == CH_UNDER) begin
                kind = K_IDENT;
            end else if (c == CH_BACKTICK) begin
                kind   = K_BACKTICK;
                n_mode = MODE_TAIL;
            end else begin
                case (c)
                    CH_DQUOTE: kind = K_DQUOTE;
                    CH_SQUOTE: kind = K_SQUOTE;
                    CH_EQ:     kind = K_EQ;
                    CH_SEMI:   kind = K_SEMI;
                    CH_COMMA:  kind = K_COMMA;
                    CH_LBRACE: kind = K_LBRACE;
                    CH_RBRACE: kind = K_RBRACE;
                    default: begin
                        kind = K_UNKNOWN;
                        err  = 1'b1;
                    end
                endcase
            end
        end else if (r_mode == MODE_TAIL && c == CH_BACKTICK) begin
            if (la_valid && la == CH_BACKTICK) begin
                if (r_tail < t_tail'(MAX_TAIL_NESTING)) begin
                    n_tail = r_tail + 1'b1;
                end else begin
                    err = 1'b1;
                end
                n_mode = MODE_HEAD;
                n_pair = 1'b1;
                kind   = K_DELIM;
            end else begin
                if (r_tail == '0) begin
                    n_mode = MODE_BODY;
                end else begin
                    n_tail = r_tail - 1'b1;
                end
                kind = K_BACKTICK;
            end
        end else if (r_mode != MODE_TAIL && c == CH_BACKTICK) begin
            if (la_valid && la == CH_BACKTICK) begin
                n_mode = MODE_HEAD;
                n_pair = 1'b1;
                kind   = K_DELIM;
            end else begin
                kind = K_UNKNOWN;
                err  = 1'b1;
            end
        end else if (c == CH_NUL) begin
            kind = K_UNKNOWN;
            err  = 1'b1;
        end else begin
            kind = K_CONTENT;
            st   = (r_run != K_CONTENT);
        end
        n_run = kind;
        if (c == CH_LF) begin
            if (r_line != '1) begin
                n_line = r_line + 1'b1;
            end
            n_col = '0;
        end else if (r_col != '1) begin
            n_col = r_col + 1'b1;
        end
        // End of text: emit eof at the current position, then return to reset values.
        if (sel[2]) begin
            kind    = K_EOF;
            st      = 1'b1;
            err     = 1'b0;
            n_mode  = MODE_BODY;
            n_ckind = CK_NONE;
            n_tail  = '0;
            n_depth = '0;
            n_run   = K_EOF;
            n_pair  = 1'b0;
            n_line  = 24'd1;
            n_col   = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_out.out_byte <= c;
            r_out.kind     <= kind;
            r_out.start    <= st;
            r_out.line_no  <= r_line;
            r_out.col_no   <= r_col;
            r_out.err      <= err;
            r_out.last     <= is_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= MODE_BODY;
            r_ckind     <= CK_NONE;
            r_tail      <= '0;
            r_depth     <= '0;
            r_run       <= K_EOF;
            r_pair      <= 1'b0;
            r_line      <= 24'd1;
            r_col       <= '0;
            r_done      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (fire) begin
                r_mode  <= n_mode;
                r_ckind <= n_ckind;
                r_tail  <= n_tail;
                r_depth <= n_depth;
                r_run   <= n_run;
                r_pair  <= n_pair;
                r_line  <= n_line;
                r_col   <= n_col;
                r_done  <= is_last ? 3'b000 : (r_done | sel);
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

endmodule

>>> hw/rtl/markup_tag_lexer_unit.sv
// Top level of the markup tag lexer: front end, job queue and back end.
//
// Slave channel: one byte per transaction. tdata carries the byte, tuser[0]
// says whether the byte is present, tlast ends the text. Each byte is held
// until the next one arrives, which serves as its one-byte lookahead.
// Master channel: one labelled byte per transaction, with kind, token start,
// line, column and error; tlast marks the final result of an input transaction.
// An end-of-text transaction flushes the held byte and adds an eof result,
// then all lexer state returns to its reset values.
// With an idle back end, the first result of an input transaction passes
// through the queue write and then the output register before it is valid
// on the master side.
// Throughput: one result per cycle while the receiver is ready; an input
// yields 0 to 3 results, which leave the back end one after another. The
// queue takes one transaction per cycle while it has room, so the front end
// keeps accepting while the receiver stalls, until four jobs are waiting.
// Reset (synchronous, active low) empties the queue, clears the hold and
// puts the lexer in body mode at line 1, column 0.
module markup_tag_lexer_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] in_byte
    input  logic [0:0]  s_axis_tuser,   // [0] byte_valid
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata,   // [7:0] out_byte, [31:8] line_no, [47:32] col_no
    output logic [5:0]  m_axis_tuser,   // [3:0] token_kind, [4] token_start, [5] error_flag
    output logic        m_axis_tlast
);
    import mtl_pkg::*;

    t_job    push_job;
    t_job    head_job;
    t_result result;
    logic    push;
    logic    pop;
    logic    full;
    logic    empty;

    mtl_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (s_axis_tvalid),
        .i_byte       (s_axis_tdata),
        .i_byte_valid (s_axis_tuser[0]),
        .i_end        (s_axis_tlast),
        .i_full       (full),
        .o_ready      (s_axis_tready),
        .o_push       (push),
        .o_job        (push_job)
    );

    mtl_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (push_job),
        .i_pop   (pop),
        .o_full  (full),
        .o_empty (empty),
        .o_head  (head_job)
    );

    mtl_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_empty  (empty),
        .i_head   (head_job),
        .o_pop    (pop),
        .o_valid  (m_axis_tvalid),
        .i_ready  (m_axis_tready),
        .o_result (result)
    );

    assign m_axis_tdata = {result.col_no, result.line_no, result.out_byte};
    assign m_axis_tuser = {result.err, result.start, result.kind};
    assign m_axis_tlast = result.last;

endmodule
